@@ hdl/pedd_pkg.sv @@
package pedd_pkg;

    localparam int ROW_LENGTH_MAX_DEF = 64;
    localparam int COST_BITS_DEF      = 24;
    localparam int FAR_BOUND          = 1000000000;

    typedef struct packed {
        logic [23:0] sample_cost;
        logic        last_sample;
    } sample_t;

    typedef struct packed {
        logic [23:0] squared_distance;
        logic        last_result;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD_APEX,
        ST_RD_SAMP,
        ST_CALC,
        ST_DIV,
        ST_CMP,
        ST_WR_FAR,
        ST_E_RD,
        ST_E_CHK,
        ST_E_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic rd_apex;
        logic rd_samp;
        logic start_div;
        logic pop;
        logic push;
        logic wr_far;
        logic emit_init;
        logic e_rd;
        logic e_adv;
        logic e_samp;
        logic e_out;
    } cmd_t;

    typedef struct packed {
        logic q_zero;
        logic closing;
        logic div_done;
        logic pop;
        logic adv;
        logic p_last;
        logic out_free;
    } status_t;

endpackage

@@ hdl/pedd_div.sv @@
module pedd_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dvs_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/pedd_dp.sv @@
module pedd_dp #(
    parameter int ROW_LENGTH_MAX = pedd_pkg::ROW_LENGTH_MAX_DEF,
    parameter int COST_BITS      = pedd_pkg::COST_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pedd_pkg::cmd_t    cmd,
    output pedd_pkg::status_t status,
    input  pedd_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output pedd_pkg::result_t result
);
    import pedd_pkg::*;

    localparam int IDX_W = $clog2(ROW_LENGTH_MAX);
    localparam int SQ_W  = 2 * IDX_W;
    localparam int NUM_W = ((COST_BITS > SQ_W) ? COST_BITS : SQ_W) + 2;
    localparam int DEN_W = IDX_W + 1;
    localparam int BND_W = (NUM_W > 32) ? NUM_W : 32;
    localparam int BA_W  = IDX_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ROW_LENGTH_MAX - 1);
    localparam logic signed [BND_W-1:0] FAR_POS = BND_W'(FAR_BOUND);
    localparam logic signed [BND_W-1:0] FAR_NEG = -FAR_POS;
    localparam logic [NUM_W-1:0] COST_MAX = (NUM_W'(1) << COST_BITS) - NUM_W'(1);

    logic [COST_BITS-1:0] sample_mem [ROW_LENGTH_MAX];
    logic [IDX_W-1:0]     apex_mem   [ROW_LENGTH_MAX];
    logic [BND_W-1:0]     bnd_mem    [ROW_LENGTH_MAX+1];

    logic [IDX_W-1:0]     load_count_reg;
    logic [IDX_W-1:0]     top_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [IDX_W-1:0]     p_reg;
    logic                 result_valid_reg;
    logic [IDX_W-1:0]     q_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic                 closing_reg;
    logic                 neg_reg;
    logic [COST_BITS-1:0] samp_q;
    logic [IDX_W-1:0]     apex_q;
    logic [BND_W-1:0]     bnd_q;
    result_t              result_reg;

    logic [COST_BITS-1:0] cost_in;
    logic                 closing_in;
    logic [IDX_W-1:0]     k_inc;
    logic [BA_W-1:0]      k_up;
    logic [SQ_W-1:0]      q_sq;
    logic [SQ_W-1:0]      r_sq;
    logic [NUM_W-1:0]     num;
    logic [NUM_W-1:0]     num_mag;
    logic [DEN_W-1:0]     den;
    logic [NUM_W-1:0]     quo;
    logic                 div_done;
    logic [BND_W-1:0]     s_mag;
    logic [BND_W-1:0]     s_val;
    logic [IDX_W-1:0]     gap;
    logic [SQ_W-1:0]      gap_sq;
    logic [NUM_W-1:0]     val;
    logic [NUM_W-1:0]     val_sat;
    logic                 bnd_we;
    logic [BA_W-1:0]      bnd_waddr;
    logic [BND_W-1:0]     bnd_wdata;
    logic                 apex_we;
    logic [IDX_W-1:0]     apex_waddr;
    logic [IDX_W-1:0]     apex_wdata;
    logic [BA_W-1:0]      bnd_raddr;

    always_comb
    begin
        cost_in    = COST_BITS'(sample.sample_cost);
        closing_in = sample.last_sample || (load_count_reg == IDX_LAST);
        k_inc      = k_reg + IDX_W'(1);
        k_up       = BA_W'(k_reg) + BA_W'(1);

        // numerator f(q) - f(r) + q^2 - r^2, two's complement
        q_sq    = SQ_W'(q_reg) * SQ_W'(q_reg);
        r_sq    = SQ_W'(apex_q) * SQ_W'(apex_q);
        num     = NUM_W'(cost_reg) - NUM_W'(samp_q) + NUM_W'(q_sq) - NUM_W'(r_sq);
        num_mag = num[NUM_W-1] ? -num : num;
        den     = (q_reg > apex_q) ? {q_reg - apex_q, 1'b0} : DEN_W'(2);

        s_mag = BND_W'(quo);
        s_val = neg_reg ? -s_mag : s_mag;

        gap     = (p_reg >= apex_q) ? (p_reg - apex_q) : (apex_q - p_reg);
        gap_sq  = SQ_W'(gap) * SQ_W'(gap);
        val     = NUM_W'(samp_q) + NUM_W'(gap_sq);
        val_sat = (val > COST_MAX) ? COST_MAX : val;

        bnd_we     = cmd.init || cmd.push || cmd.wr_far;
        bnd_waddr  = cmd.init ? '0 : k_up;
        bnd_wdata  = cmd.init ? FAR_NEG : (cmd.push ? s_val : FAR_POS);
        apex_we    = cmd.init || cmd.push;
        apex_waddr = cmd.init ? '0 : k_inc;
        apex_wdata = cmd.init ? '0 : q_reg;
        bnd_raddr  = cmd.rd_samp ? BA_W'(k_reg) : k_up;
    end

    pedd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (num_mag),
        .divisor  (den),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg   <= '0;
            top_reg          <= '0;
            k_reg            <= '0;
            p_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                load_count_reg <= closing_in ? '0 : load_count_reg + IDX_W'(1);
                k_reg          <= top_reg;
            end
            if (cmd.init || cmd.emit_init)
            begin
                k_reg <= '0;
            end
            if (cmd.pop)
            begin
                k_reg <= k_reg - IDX_W'(1);
            end
            if (cmd.push || cmd.e_adv)
            begin
                k_reg <= k_inc;
            end
            if (cmd.wr_far)
            begin
                top_reg <= k_reg;
            end
            if (cmd.emit_init)
            begin
                p_reg <= '0;
            end
            if (cmd.e_out)
            begin
                p_reg            <= p_reg + IDX_W'(1);
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_mem[load_count_reg] <= cost_in;
            q_reg       <= load_count_reg;
            cost_reg    <= cost_in;
            closing_reg <= closing_in;
        end
        if (bnd_we)
        begin
            bnd_mem[bnd_waddr] <= bnd_wdata;
        end
        if (apex_we)
        begin
            apex_mem[apex_waddr] <= apex_wdata;
        end
        if (cmd.rd_apex || cmd.e_rd)
        begin
            apex_q <= apex_mem[k_reg];
        end
        if (cmd.rd_samp || cmd.e_rd)
        begin
            bnd_q <= bnd_mem[bnd_raddr];
        end
        if (cmd.rd_samp || cmd.e_samp)
        begin
            samp_q <= sample_mem[apex_q];
        end
        if (cmd.start_div)
        begin
            neg_reg <= num[NUM_W-1];
        end
        if (cmd.e_out)
        begin
            result_reg.squared_distance <= 24'(val_sat);
            result_reg.last_result      <= (p_reg == q_reg);
        end
    end

    always_comb
    begin
        status.q_zero   = (load_count_reg == '0);
        status.closing  = closing_reg;
        status.div_done = div_done;
        status.pop      = (k_reg != '0) && ($signed(s_val) <= $signed(bnd_q));
        status.adv      = (k_reg < top_reg) && ($signed(bnd_q) < $signed(BND_W'(p_reg)));
        status.p_last   = (p_reg == q_reg);
        status.out_free = !result_valid_reg || result_ready;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hdl/pedd_ctrl.sv @@
module pedd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  pedd_pkg::status_t status,
    output pedd_pkg::cmd_t    cmd
);
    import pedd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.q_zero ? ST_INIT : ST_RD_APEX;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_WR_FAR;
            end
            ST_RD_APEX:
            begin
                cmd.rd_apex = 1'b1;
                state_next  = ST_RD_SAMP;
            end
            ST_RD_SAMP:
            begin
                cmd.rd_samp = 1'b1;
                state_next  = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // drop the top parabola while its start is not below the new crossing and it is not the last one left
                if (status.pop)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_RD_APEX;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_WR_FAR;
                end
            end
            ST_WR_FAR:
            begin
                cmd.wr_far = 1'b1;
                if (status.closing)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_E_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_E_RD:
            begin
                cmd.e_rd   = 1'b1;
                state_next = ST_E_CHK;
            end
            ST_E_CHK:
            begin
                if (status.adv)
                begin
                    cmd.e_adv  = 1'b1;
                    state_next = ST_E_RD;
                end
                else
                begin
                    cmd.e_samp = 1'b1;
                    state_next = ST_E_OUT;
                end
            end
            ST_E_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.e_out  = 1'b1;
                    state_next = status.p_last ? ST_IDLE : ST_E_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/parabola_envelope_distance_1d.sv @@
// Load: a row's first sample only initializes the envelope; any later sample
// computes a crossing with each envelope parabola visited on the shared
// bit-serial divider, NUM_W bits wide (26 at default widths).
// Emit: each result steps past envelope boundaries, then waits while the output stalls.
// Asynchronous active-low reset empties the row and returns to idle.
module parabola_envelope_distance_1d #(
    parameter int ROW_LENGTH_MAX = pedd_pkg::ROW_LENGTH_MAX_DEF,
    parameter int COST_BITS      = pedd_pkg::COST_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  pedd_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output pedd_pkg::result_t result
);
    import pedd_pkg::*;

    cmd_t    cmd;
    status_t status;

    pedd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    pedd_dp #(
        .ROW_LENGTH_MAX (ROW_LENGTH_MAX),
        .COST_BITS      (COST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
